>>> rtl/yuv_to_hue_saturation_assert.svh
// Assertion macros for the hue/saturation converter.
// Each check is clocked on clk and disabled while rst_n is low.
`ifndef YUV_TO_HUE_SATURATION_ASSERT_SVH
`define YUV_TO_HUE_SATURATION_ASSERT_SVH
`ifndef SYNTHESIS
`define YTH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define YTH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define YTH_ASSERT_IMPL(label, ante, cons)
`define YTH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/yth_pkg.sv
`default_nettype none
package yth_pkg;

  // Chroma coefficients in units of 1/256
  localparam int COEF_RV = 103;
  localparam int COEF_GU = 88;
  localparam int COEF_GV = 183;
  localparam int COEF_BU = 198;

  // Divider geometry: both quotients stay below 2**DIV_Q_W
  localparam int DIV_Q_W     = 9;
  localparam int SAT_NUM_W   = 16;
  localparam int SAT_DEN_W   = 8;
  localparam int HUE_NUM_W   = 19;
  localparam int HUE_DEN_W   = 11;

  // Accept edge to the edge that takes the result
  localparam int PIPE_LAT = DIV_Q_W + 3;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       last_pixel;
  } in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic       last_out;
  } out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } rgb_t;

  typedef struct packed {
    logic [SAT_NUM_W-1:0] sat_num;
    logic [SAT_DEN_W-1:0] sat_den;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [HUE_DEN_W-1:0] hue_den;
    logic                 gray;
    logic                 last;
  } prep_t;

endpackage
`default_nettype wire

>>> rtl/yth_rgb.sv
`default_nettype none
module yth_rgb (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire yth_pkg::in_t  in_pix,
  output logic               rgb_vld_r,
  output yth_pkg::rgb_t      rgb_r
);
  import yth_pkg::*;

  function automatic logic [7:0] clamp8(input logic signed [11:0] x);
    logic [7:0] res;
    if (x < 12'sd0) begin
      res = 8'd0;
    end else if (x > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  logic signed [8:0]  u_s, v_s;
  logic signed [11:0] y_s;
  logic signed [17:0] p_rv, p_gu, p_gv, p_bu;
  logic signed [11:0] r_s, g_s, b_s;
  rgb_t               rgb_nxt;

  assign y_s = $signed({4'b0000, in_pix.luma});
  assign u_s = $signed({1'b0, in_pix.chroma_u}) - 9'sd128;
  assign v_s = $signed({1'b0, in_pix.chroma_v}) - 9'sd128;

  assign p_rv = 18'(v_s) * $signed(18'(COEF_RV));
  assign p_gu = 18'(u_s) * $signed(18'(COEF_GU));
  assign p_gv = 18'(v_s) * $signed(18'(COEF_GV));
  assign p_bu = 18'(u_s) * $signed(18'(COEF_BU));

  // Arithmetic shifts floor toward minus infinity
  assign r_s = y_s + 12'(v_s) + 12'(p_rv >>> 8);
  assign g_s = y_s - (12'(p_gu >>> 8) + 12'(p_gv >>> 8));
  assign b_s = y_s + 12'(u_s) + 12'(p_bu >>> 8);

  always_comb begin
    rgb_nxt.r    = clamp8(r_s);
    rgb_nxt.g    = clamp8(g_s);
    rgb_nxt.b    = clamp8(b_s);
    rgb_nxt.last = in_pix.last_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_vld_r <= 1'b0;
    end else begin
      rgb_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rgb_r <= rgb_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/yth_prep.sv
`default_nettype none
module yth_prep (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           rgb_vld,
  input  wire yth_pkg::rgb_t  rgb,
  output logic                prep_vld_r,
  output yth_pkg::prep_t      prep_r
);
  import yth_pkg::*;

  logic [7:0]  mx, mn, d, den;
  logic [8:0]  sum;
  logic [10:0] d11, num;
  prep_t       prep_nxt;

  always_comb begin
    mx = (rgb.r > rgb.g) ? rgb.r : rgb.g;
    mx = (mx > rgb.b) ? mx : rgb.b;
    mn = (rgb.r < rgb.g) ? rgb.r : rgb.g;
    mn = (mn < rgb.b) ? mn : rgb.b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    d11 = {3'b000, d};
    // Lower half of lightness divides by sum, upper half by 510 - sum
    den = (sum <= 9'd255) ? sum[7:0] : 8'(10'd510 - {1'b0, sum});
  end

  always_comb begin
    priority if (rgb.r == mx) begin
      num = (rgb.g == mn) ? (11'd5 * d11 + {3'b000, 8'(mx - rgb.b)})
                          : (d11 - {3'b000, 8'(mx - rgb.g)});
    end else if (rgb.g == mx) begin
      num = (rgb.b == mn) ? (d11 + {3'b000, 8'(mx - rgb.r)})
                          : (11'd3 * d11 - {3'b000, 8'(mx - rgb.b)});
    end else begin
      num = (rgb.r == mn) ? (11'd3 * d11 + {3'b000, 8'(mx - rgb.g)})
                          : (11'd5 * d11 - {3'b000, 8'(mx - rgb.r)});
    end
  end

  always_comb begin
    prep_nxt.sat_num = {d, 8'h00} + SAT_NUM_W'(den >> 1);
    prep_nxt.sat_den = den;
    prep_nxt.hue_num = {num, 8'h00} + HUE_NUM_W'(11'd3 * d11);
    prep_nxt.hue_den = 11'd6 * d11;
    // A black pixel has d == 0 too, so one flag covers both
    prep_nxt.gray    = (d == 8'd0);
    prep_nxt.last    = rgb.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else begin
      prep_vld_r <= rgb_vld;
    end
  end

  always_ff @(posedge clk) begin
    prep_r <= prep_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/yth_div.sv
`default_nettype none
module yth_div #(
  parameter int NUM_W = yth_pkg::HUE_NUM_W,
  parameter int DEN_W = yth_pkg::HUE_DEN_W,
  parameter int Q_W   = yth_pkg::DIV_Q_W
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo
);
  import yth_pkg::*;

  localparam int CW = (NUM_W > DEN_W + Q_W - 1) ? NUM_W : DEN_W + Q_W - 1;

  // One quotient bit per stage, most significant first
  logic [CW-1:0]    rem_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;
    logic [CW-1:0]    rem_in, trial;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = CW'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign trial = CW'(den_in) << K;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      q_r[i] <= q_in | (Q_W'(ge) << K);
    end

    if (i < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? (rem_in - trial) : rem_in;
        den_r[i] <= den_in;
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule
`default_nettype wire

>>> rtl/yuv_to_hue_saturation.sv
`default_nettype none
`include "yuv_to_hue_saturation_assert.svh"
// YUV pixel to HSL hue and saturation. One pixel is taken in every clock
// cycle: busy is tied low, so start alone marks an item. Each result sits
// on out_data for exactly one cycle with out_valid high, in input order;
// the receiver cannot stall, so results must be taken as they appear.
// A pixel passes through one stage for RGB conversion and clamping, one
// stage for max/min and sector selection, nine restoring-division stages
// (one quotient bit each, shared shape for hue and saturation) and one
// output register.
// Gray and black pixels give hue 0 and saturation 0; a hue of one full
// turn wraps to 0 and full saturation is held at 255.
module yuv_to_hue_saturation (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire yth_pkg::in_t  in_data,
  output logic               out_valid,
  output yth_pkg::out_t      out_data
);
  import yth_pkg::*;

  logic            in_vld;
  logic            rgb_vld;
  rgb_t            rgb;
  logic            prep_vld;
  prep_t           prep;
  logic [DIV_Q_W-1:0] sat_q, hue_q;

  // Side pipe carries valid, gray flag and frame marker alongside the divider
  logic [DIV_Q_W-1:0] vld_pipe_r, gray_pipe_r, last_pipe_r;

  logic  out_valid_r;
  out_t  out_data_r, out_data_nxt;

  // Never stall: the pipeline advances every cycle
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  yth_rgb u_rgb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld),
    .in_pix    (in_data),
    .rgb_vld_r (rgb_vld),
    .rgb_r     (rgb)
  );

  yth_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .rgb_vld    (rgb_vld),
    .rgb        (rgb),
    .prep_vld_r (prep_vld),
    .prep_r     (prep)
  );

  yth_div #(
    .NUM_W (SAT_NUM_W),
    .DEN_W (SAT_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_sat_div (
    .clk (clk),
    .num (prep.sat_num),
    .den (prep.sat_den),
    .quo (sat_q)
  );

  yth_div #(
    .NUM_W (HUE_NUM_W),
    .DEN_W (HUE_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_hue_div (
    .clk (clk),
    .num (prep.hue_num),
    .den (prep.hue_den),
    .quo (hue_q)
  );

  // Advance the side pipe in step with the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_pipe_r <= '0;
    end else begin
      vld_pipe_r <= {vld_pipe_r[DIV_Q_W-2:0], prep_vld};
    end
  end

  always_ff @(posedge clk) begin
    gray_pipe_r <= {gray_pipe_r[DIV_Q_W-2:0], prep.gray};
    last_pipe_r <= {last_pipe_r[DIV_Q_W-2:0], prep.last};
  end

  // Drop the quotients for gray pixels (the divisor may be zero there),
  // wrap hue at a full turn and hold saturation at 255
  always_comb begin
    if (gray_pipe_r[DIV_Q_W-1]) begin
      out_data_nxt.hue        = 8'd0;
      out_data_nxt.saturation = 8'd0;
    end else begin
      out_data_nxt.hue        = hue_q[7:0];
      out_data_nxt.saturation = sat_q[DIV_Q_W-1] ? 8'hFF : sat_q[7:0];
    end
    out_data_nxt.last_out = last_pipe_r[DIV_Q_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_pipe_r[DIV_Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted pixel yields a result after the fixed latency
  `YTH_ASSERT_IMPL(a_lat, in_vld, ##PIPE_LAT out_valid)
  // Nonzero chroma spread always gives nonzero saturation, so zero
  // saturation must come with zero hue
  `YTH_ASSERT_IMPL(a_gray, out_valid && (out_data.saturation == 8'd0),
                   out_data.hue == 8'd0)
  // The frame marker lines up with its own pixel
  `YTH_ASSERT_IMPL(a_last, out_valid,
                   out_data.last_out == $past(in_data.last_pixel, PIPE_LAT))
  // Valid in the divider pipe always reaches the output next cycle
  `YTH_ASSERT_NEXT(a_tail, vld_pipe_r[DIV_Q_W-1], out_valid)

endmodule
`default_nettype wire
